/* rtl/dcm_gyro_attitude_integrator_core_defines.svh */
// Assertion macros shared by the gyro attitude integrator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef DCM_GYRO_ATTITUDE_INTEGRATOR_CORE_DEFINES_SVH
`define DCM_GYRO_ATTITUDE_INTEGRATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DGAI_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DGAI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dgai_pkg.sv */
// Package of the gyro attitude integrator: default sizes, fixed-point constants
// and the CORDIC arctangent table. No dependencies.
package dgai_pkg;

  localparam int MATRIX_WIDTH_DEF = 32;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic signed [32:0] RATE_SCALE  = 33'sd314410567;
  localparam logic signed [65:0] INC_LIMIT   = 66'sd2147483647;
  localparam logic signed [25:0] ROLL_LIMIT  = 26'sd46080;
  localparam logic signed [25:0] PITCH_LIMIT = 26'sd23040;
  localparam logic signed [25:0] QUARTER_TURN = 26'sd5898240;

  // Arctangent of 2^-i in units of 2^-16 degree.
  localparam logic [21:0] ANGLE_TAB [0:31] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
    22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2,
    22'd1, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0
  };

endpackage

/* rtl/dgai_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module dgai_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 9
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/dcm_gyro_attitude_integrator_core.sv */
// Top level of the gyro attitude integrator: sequencer, shared multiplier,
// CORDIC and square root units. Depends on dgai_pkg, dgai_ram and the defines header.
//
// Usage: one gyro sample is taken per transfer on the input channel (three body
// rates and a time step). The block advances its direction cosine matrix by one
// Euler step and gives one result transfer with roll and pitch.
// The matrix lives in a 9-entry RAM and is updated row by row: a row is read,
// its three new entries are formed with a shared 33x33 multiplier (two
// products per entry, each through states S_MA, S_MB and S_MC) and written back.
// Each item passes through the increments, the matrix update, a CORDIC pass
// for roll, 32 steps of the square root used by pitch, a CORDIC pass for pitch
// and the setup and handoff states.
// One item is worked on at a time; the next input transfer is taken as soon
// as the previous result sits in the output register.
// If the receiver stalls, the finished result waits in the output register
// and a following item may still be accepted and worked on; it stops before
// its own result until the register is free.
// After reset the matrix reads as the identity until the first item has
// written all entries; no clearing pass is needed.
`include "dcm_gyro_attitude_integrator_core_defines.svh"

module dcm_gyro_attitude_integrator_core #(
  parameter int MATRIX_WIDTH = dgai_pkg::MATRIX_WIDTH_DEF,
  parameter int CORDIC_STEPS = dgai_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] rate_x_i,
  input  logic signed [15:0] rate_y_i,
  input  logic signed [15:0] rate_z_i,
  input  logic [15:0]        step_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [16:0] roll_angle_o,
  output logic signed [15:0] pitch_angle_o
);
  import dgai_pkg::*;

  localparam int MW = MATRIX_WIDTH;
  localparam int AW = MW + 4;
  localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [CW-1:0] CLAST = CW'(CORDIC_STEPS - 1);
  localparam int QSH = (MW >= 32) ? MW - 32 : 0;
  localparam int QLS = (MW < 32) ? 32 - MW : 0;
  localparam logic signed [65:0] QRND = (QSH == 0) ? 66'sd0 :
                                        (66'sd1 <<< ((QSH == 0) ? 0 : QSH - 1));
  localparam logic signed [MW-1:0] ONE  = {2'b01, {(MW-2){1'b0}}};
  localparam logic signed [MW-1:0] MAXV = {1'b0, {(MW-1){1'b1}}};
  localparam logic signed [MW-1:0] MINV = {1'b1, {(MW-1){1'b0}}};

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_INC_A = 5'd1;
  localparam logic [4:0] S_INC_B = 5'd2;
  localparam logic [4:0] S_INC_C = 5'd3;
  localparam logic [4:0] S_RD    = 5'd4;
  localparam logic [4:0] S_RDW   = 5'd5;
  localparam logic [4:0] S_MA    = 5'd6;
  localparam logic [4:0] S_MB    = 5'd7;
  localparam logic [4:0] S_MC    = 5'd8;
  localparam logic [4:0] S_WR    = 5'd9;
  localparam logic [4:0] S_CSET  = 5'd10;
  localparam logic [4:0] S_CRUN  = 5'd11;
  localparam logic [4:0] S_PS    = 5'd12;
  localparam logic [4:0] S_SQ    = 5'd13;
  localparam logic [4:0] S_SQW   = 5'd14;
  localparam logic [4:0] S_ISQ   = 5'd15;
  localparam logic [4:0] S_DONE  = 5'd16;

  function automatic logic signed [32:0] to_q30(input logic signed [MW-1:0] v);
    logic signed [65:0] w;
    w = {{(66-MW){v[MW-1]}}, v};
    w = ((w + QRND) >>> QSH) <<< QLS;
    return w[32:0];
  endfunction

  // Control state.
  logic [4:0]    state_q, state_d;
  logic [1:0]    axis_q, axis_d;
  logic [1:0]    row_q, row_d;
  logic [1:0]    col_q, col_d;
  logic          m_q, m_d;
  logic          pass_q, pass_d;
  logic [CW-1:0] ccnt_q, ccnt_d;
  logic [4:0]    icnt_q, icnt_d;
  logic          init_q, init_d;
  logic          out_valid_q, out_valid_d;

  // Datapath registers.
  logic signed [15:0]   rate_q [0:2];
  logic [15:0]          dt_q;
  logic signed [31:0]   inc_q [0:2];
  logic signed [MW-1:0] rowbuf_q [0:2];
  logic signed [AW-1:0] acc_q, acc_d;
  logic signed [65:0]   xr_q;
  logic signed [65:0]   prod_q;
  logic signed [MW-1:0] c20_q, c21_q, c22_q;
  logic signed [35:0]   cx_q, cx_d, cy_q, cy_d;
  logic signed [25:0]   cz_q, cz_d;
  logic                 zf_q, zf_d;
  logic signed [31:0]   s_q;
  logic [63:0]          n_q, n_d, res_q, res_d;
  logic signed [16:0]   roll_q;
  logic signed [15:0]   pitch_q;
  logic signed [16:0]   roll_out_q;
  logic signed [15:0]   pitch_out_q;

  logic                 in_xfer;
  logic signed [32:0]   ma, mb;
  logic signed [65:0]   prod_d;
  logic [1:0]           kk;
  logic signed [31:0]   wv;
  logic signed [MW-1:0] rb_k, rd_val, wr_val;
  logic signed [65:0]   rb_ext, inc_t, mq_t;
  logic [3:0]           addr;
  logic                 we;
  logic [MW-1:0]        ram_rdata;
  logic signed [35:0]   dx, dy, ang;
  logic signed [25:0]   zr, zrnd, zneg;
  logic signed [16:0]   roll_v;
  logic signed [15:0]   pitch_v;
  logic signed [32:0]   cy0, cx0, sq30;
  logic [63:0]          bitv, sumv;

  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign addr       = 4'({row_q, 1'b0}) + 4'(row_q) + 4'(col_q);
  assign we         = (state_q == S_WR);

  dgai_ram #(
    .WIDTH(MW),
    .DEPTH(9)
  ) u_matrix_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(addr),
    .wdata_i(wr_val),
    .raddr_i(addr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    case ({col_q, m_q})
      3'b000:  kk = 2'd1;
      3'b001:  kk = 2'd2;
      3'b010:  kk = 2'd2;
      3'b011:  kk = 2'd0;
      3'b100:  kk = 2'd0;
      3'b101:  kk = 2'd1;
      default: kk = 2'd0;
    endcase
    case ({kk, col_q})
      4'b0001: wv = -inc_q[2];
      4'b0010: wv = inc_q[1];
      4'b0100: wv = inc_q[2];
      4'b0110: wv = -inc_q[0];
      4'b1000: wv = -inc_q[1];
      4'b1001: wv = inc_q[0];
      default: wv = '0;
    endcase
    case (kk)
      2'd0:    rb_k = rowbuf_q[0];
      2'd1:    rb_k = rowbuf_q[1];
      default: rb_k = rowbuf_q[2];
    endcase
  end

  assign rb_ext = {{(66-MW){rb_k[MW-1]}}, rb_k};
  assign rd_val = init_q ? $signed(ram_rdata) : ((row_q == col_q) ? ONE : '0);
  assign inc_t  = (prod_q + 66'sd134217728) >>> 28;
  assign mq_t   = (xr_q + ((prod_q + 66'sd536870912) >>> 16)) >>> 14;

  always_comb begin
    if (acc_q > AW'(MAXV)) begin
      wr_val = MAXV;
    end else if (acc_q < AW'(MINV)) begin
      wr_val = MINV;
    end else begin
      wr_val = acc_q[MW-1:0];
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      S_INC_A: begin
        case (axis_q)
          2'd0:    ma = 33'(rate_q[0]);
          2'd1:    ma = 33'(rate_q[1]);
          default: ma = 33'(rate_q[2]);
        endcase
        mb = {17'b0, dt_q};
      end
      S_INC_B: begin
        ma = prod_q[32:0];
        mb = RATE_SCALE;
      end
      S_MA: begin
        ma = rb_ext[48:16];
        mb = 33'(wv);
      end
      S_MB: begin
        ma = {17'b0, rb_k[15:0]};
        mb = 33'(wv);
      end
      S_SQ: begin
        ma = 33'(s_q);
        mb = 33'(s_q);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod_d = ma * mb;

  // CORDIC step and readout rounding.
  assign dx   = cy_q >>> ccnt_q;
  assign dy   = cx_q >>> ccnt_q;
  assign ang  = 36'(ANGLE_TAB[5'(ccnt_q)]);
  assign zr   = zf_q ? 26'sd0 : cz_d;
  assign zrnd = (zr + 26'sd128) >>> 8;
  assign zneg = -zrnd;

  always_comb begin
    if (zrnd > ROLL_LIMIT) begin
      roll_v = 17'(ROLL_LIMIT);
    end else if (zrnd < -ROLL_LIMIT) begin
      roll_v = 17'(-ROLL_LIMIT);
    end else begin
      roll_v = zrnd[16:0];
    end
    if (zneg > PITCH_LIMIT) begin
      pitch_v = 16'(PITCH_LIMIT);
    end else if (zneg < -PITCH_LIMIT) begin
      pitch_v = 16'(-PITCH_LIMIT);
    end else begin
      pitch_v = zneg[15:0];
    end
  end

  assign sq30 = to_q30(c20_q);
  assign cy0  = pass_q ? 33'(s_q) : to_q30(c21_q);
  assign cx0  = pass_q ? {1'b0, res_q[31:0]} : to_q30(c22_q);
  assign bitv = 64'd1 << (6'd62 - {icnt_q, 1'b0});
  assign sumv = res_q + bitv;

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    row_d       = row_q;
    col_d       = col_q;
    m_d         = m_q;
    pass_d      = pass_q;
    ccnt_d      = ccnt_q;
    icnt_d      = icnt_q;
    init_d      = init_q;
    out_valid_d = out_valid_q && !out_ready_i;
    acc_d       = acc_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cz_d        = cz_q;
    zf_d        = zf_q;
    n_d         = n_q;
    res_d       = res_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          axis_d  = 2'd0;
          state_d = S_INC_A;
        end
      end
      S_INC_A: state_d = S_INC_B;
      S_INC_B: state_d = S_INC_C;
      S_INC_C: begin
        axis_d = axis_q + 2'd1;
        if (axis_q == 2'd2) begin
          row_d   = 2'd0;
          col_d   = 2'd0;
          state_d = S_RD;
        end else begin
          state_d = S_INC_A;
        end
      end
      S_RD: state_d = S_RDW;
      S_RDW: begin
        if (col_q == 2'd2) begin
          col_d   = 2'd0;
          m_d     = 1'b0;
          state_d = S_MA;
        end else begin
          col_d   = col_q + 2'd1;
          state_d = S_RD;
        end
      end
      S_MA: begin
        if (!m_q) begin
          case (col_q)
            2'd0:    acc_d = AW'(rowbuf_q[0]);
            2'd1:    acc_d = AW'(rowbuf_q[1]);
            default: acc_d = AW'(rowbuf_q[2]);
          endcase
        end
        state_d = S_MB;
      end
      S_MB: state_d = S_MC;
      S_MC: begin
        acc_d = acc_q + mq_t[AW-1:0];
        if (!m_q) begin
          m_d     = 1'b1;
          state_d = S_MA;
        end else begin
          state_d = S_WR;
        end
      end
      S_WR: begin
        m_d = 1'b0;
        if (col_q == 2'd2) begin
          col_d = 2'd0;
          row_d = row_q + 2'd1;
          if (row_q == 2'd2) begin
            init_d  = 1'b1;
            pass_d  = 1'b0;
            state_d = S_CSET;
          end else begin
            state_d = S_RD;
          end
        end else begin
          col_d   = col_q + 2'd1;
          state_d = S_MA;
        end
      end
      S_CSET: begin
        zf_d   = (cx0 == 33'sd0) && (cy0 == 33'sd0);
        ccnt_d = '0;
        if (cx0 < 33'sd0) begin
          if (cy0 >= 33'sd0) begin
            cx_d = 36'(cy0);
            cy_d = -36'(cx0);
            cz_d = QUARTER_TURN;
          end else begin
            cx_d = -36'(cy0);
            cy_d = 36'(cx0);
            cz_d = -QUARTER_TURN;
          end
        end else begin
          cx_d = 36'(cx0);
          cy_d = 36'(cy0);
          cz_d = '0;
        end
        state_d = S_CRUN;
      end
      S_CRUN: begin
        if (cy_q > 36'sd0) begin
          cx_d = cx_q + dx;
          cy_d = cy_q - dy;
          cz_d = cz_q + ang[25:0];
        end else begin
          cx_d = cx_q - dx;
          cy_d = cy_q + dy;
          cz_d = cz_q - ang[25:0];
        end
        ccnt_d = ccnt_q + CW'(1);
        if (ccnt_q == CLAST) begin
          state_d = pass_q ? S_DONE : S_PS;
        end
      end
      S_PS: state_d = S_SQ;
      S_SQ: state_d = S_SQW;
      S_SQW: begin
        n_d     = 64'd1152921504606846976 - prod_q[63:0];
        res_d   = '0;
        icnt_d  = '0;
        state_d = S_ISQ;
      end
      S_ISQ: begin
        if (n_q >= sumv) begin
          n_d   = n_q - sumv;
          res_d = (res_q >> 1) + bitv;
        end else begin
          res_d = res_q >> 1;
        end
        icnt_d = icnt_q + 5'd1;
        if (icnt_q == 5'd31) begin
          pass_d  = 1'b1;
          state_d = S_CSET;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      m_q         <= 1'b0;
      pass_q      <= 1'b0;
      ccnt_q      <= '0;
      icnt_q      <= '0;
      init_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      row_q       <= row_d;
      col_q       <= col_d;
      m_q         <= m_d;
      pass_q      <= pass_d;
      ccnt_q      <= ccnt_d;
      icnt_q      <= icnt_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    cz_q   <= cz_d;
    zf_q   <= zf_d;
    n_q    <= n_d;
    res_q  <= res_d;
    if (in_xfer) begin
      rate_q[0] <= rate_x_i;
      rate_q[1] <= rate_y_i;
      rate_q[2] <= rate_z_i;
      dt_q      <= step_time_i;
    end
    if (state_q == S_INC_C) begin
      if (inc_t > INC_LIMIT) begin
        inc_q[axis_q] <= 32'sd2147483647;
      end else if (inc_t < -INC_LIMIT) begin
        inc_q[axis_q] <= -32'sd2147483647;
      end else begin
        inc_q[axis_q] <= inc_t[31:0];
      end
    end
    if (state_q == S_RDW) begin
      rowbuf_q[col_q] <= rd_val;
    end
    if (state_q == S_MB) begin
      xr_q <= prod_q;
    end
    if (state_q == S_WR && row_q == 2'd2) begin
      case (col_q)
        2'd0:    c20_q <= wr_val;
        2'd1:    c21_q <= wr_val;
        default: c22_q <= wr_val;
      endcase
    end
    if (state_q == S_PS) begin
      if (sq30 > 33'sd1073741824) begin
        s_q <= 32'sd1073741824;
      end else if (sq30 < -33'sd1073741824) begin
        s_q <= -32'sd1073741824;
      end else begin
        s_q <= sq30[31:0];
      end
    end
    if (state_q == S_CRUN && ccnt_q == CLAST && !pass_q) begin
      roll_q <= roll_v;
    end
    if (state_q == S_CRUN && ccnt_q == CLAST && pass_q) begin
      pitch_q <= pitch_v;
    end
    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      pitch_out_q <= pitch_q;
      roll_out_q  <= roll_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign roll_angle_o  = roll_out_q;
  assign pitch_angle_o = pitch_out_q;

  `DGAI_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == S_INC_A, "accepted item did not start the increments")
  `DGAI_ASSERT_NEXT(a_done_delivers, clk_i, rst_ni, (state_q == S_DONE) && (!out_valid_q || out_ready_i), out_valid_q && (state_q == S_IDLE), "finished result not placed in the output register")
  `DGAI_ASSERT_SAME(a_root_bound, clk_i, rst_ni, (state_q == S_CSET) && pass_q, res_q <= 64'd1073741824, "square root exceeds one")
  `DGAI_ASSERT_SAME(a_cordic_count, clk_i, rst_ni, state_q == S_CRUN, ccnt_q <= CLAST, "CORDIC step count out of range")

endmodule

/* bench/tb_top.sv */
// Self-checking bench for dcm_gyro_attitude_integrator_core: drives gyro samples,
// predicts roll and pitch from its own direction cosine matrix copy and checks each result.
// Depends on dgai_pkg and the core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dgai_pkg::*;

  localparam int MW = MATRIX_WIDTH_DEF;
  localparam int NSTEPS = CORDIC_STEPS_DEF;
  localparam int NUM_RANDOM = 1780;
  localparam int LONG_HOLD = 800;

  typedef struct {
    logic signed [16:0] roll;
    logic signed [15:0] pitch;
  } attitude_t;

  class attitude_scoreboard;
    longint dcm[9];
    attitude_t expected_q[$];
    int errors;

    function new();
      for (int i = 0; i < 9; i++) dcm[i] = (i % 4 == 0) ? (longint'(1) <<< (MW - 2)) : 0;
      errors = 0;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint to_q30(longint v);
      if (MW > 32) return (v + (longint'(1) <<< (MW - 33))) >>> (MW - 32);
      return v <<< (32 - MW);
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function longint arctan(longint y, longint x);
      longint z, t, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y; y = -t; z = 90 * 65536;
        end else begin
          x = -y; y = t; z = -90 * 65536;
        end
      end
      for (int i = 0; i < (NSTEPS > 32 ? 32 : NSTEPS); i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx; y -= dy; z += longint'(ANGLE_TAB[i]);
        end else begin
          x -= dx; y += dy; z -= longint'(ANGLE_TAB[i]);
        end
      end
      return z;
    endfunction

    function void note_sample(logic signed [15:0] rx, logic signed [15:0] ry,
                              logic signed [15:0] rz, logic [15:0] dt);
      longint inc[3], w[9], nxt[9], rate, acc, hi, s, c, roll, pitch;
      attitude_t e;
      hi = (longint'(1) <<< (MW - 1)) - 1;
      for (int i = 0; i < 3; i++) begin
        rate = (i == 0) ? longint'(rx) : ((i == 1) ? longint'(ry) : longint'(rz));
        inc[i] = clamp((rate * longint'(dt) * 314410567 + (longint'(1) <<< 27)) >>> 28,
                       -2147483647, 2147483647);
      end
      w = '{0, -inc[2], inc[1], inc[2], 0, -inc[0], -inc[1], inc[0], 0};
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = dcm[i * 3 + j];
          for (int k = 0; k < 3; k++)
            acc += (dcm[i * 3 + k] * w[k * 3 + j] + (longint'(1) <<< 29)) >>> 30;
          nxt[i * 3 + j] = clamp(acc, -hi - 1, hi);
        end
      dcm = nxt;
      roll = clamp((arctan(to_q30(dcm[7]), to_q30(dcm[8])) + 128) >>> 8, -46080, 46080);
      s = clamp(to_q30(dcm[6]), -(longint'(1) <<< 30), longint'(1) <<< 30);
      c = longint'(root((64'd1 << 60) - longint'(s * s)));
      pitch = clamp(-((arctan(s, c) + 128) >>> 8), -23040, 23040);
      e.roll = roll[16:0];
      e.pitch = pitch[15:0];
      expected_q.push_back(e);
    endfunction

    function void check_result(logic signed [16:0] roll, logic signed [15:0] pitch);
      attitude_t e;
      if (expected_q.size() == 0) begin
        $error("result transfer with no expected attitude: roll %0d pitch %0d", roll, pitch);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (roll !== e.roll) begin
        $error("roll_angle: expected %0d, got %0d", e.roll, roll);
        errors++;
      end
      if (pitch !== e.pitch) begin
        $error("pitch_angle: expected %0d, got %0d", e.pitch, pitch);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] rate_x_i = '0;
  logic signed [15:0] rate_y_i = '0;
  logic signed [15:0] rate_z_i = '0;
  logic [15:0] step_time_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [16:0] roll_angle_o;
  logic signed [15:0] pitch_angle_o;

  attitude_scoreboard sb = new();
  int samples_sent = 0;

  dcm_gyro_attitude_integrator_core u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .rate_x_i, .rate_y_i, .rate_z_i,
    .step_time_i, .out_valid_o, .out_ready_i, .roll_angle_o, .pitch_angle_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_sample(input logic [15:0] rx, input logic [15:0] ry,
                             input logic [15:0] rz, input logic [15:0] dt);
    int gap;
    in_valid_i <= 1'b1;
    rate_x_i <= rx;
    rate_y_i <= ry;
    rate_z_i <= rz;
    step_time_i <= dt;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(rx, ry, rz, dt);
    samples_sent++;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random_sample();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 7)
      send_sample(16'($urandom_range(0, 8000) - 4000), 16'($urandom_range(0, 8000) - 4000),
                  16'($urandom_range(0, 8000) - 4000), 16'($urandom_range(500, 5000)));
    else if (kind == 7)
      send_sample(16'($urandom), 16'($urandom), 16'($urandom), '0);
    else
      send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(roll_angle_o, pitch_angle_o);
  end

  initial begin
    bit held;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      if (!held && samples_sent >= 300) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      if ((samples_sent / 100) % 3 == 1) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
      @(posedge clk_i);
    end
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_sample(16'sd0, 16'sd0, 16'sd0, 16'd0);
    send_sample(16'sd0, 16'sd0, 16'sd0, 16'd65535);
    send_sample(16'sd1440, 16'sd0, 16'sd0, 16'd1000);
    send_sample(16'sd0, 16'sd1440, 16'sd0, 16'd1000);
    send_sample(16'sd0, 16'sd0, 16'sd1440, 16'd1000);
    send_sample(-16'sd1440, -16'sd1440, -16'sd1440, 16'd1000);
    send_sample(16'sd32767, 16'sd0, 16'sd0, 16'd1);
    send_sample(-16'sd32768, 16'sd0, 16'sd0, 16'd1);
    send_sample(16'sd1000, 16'sd2000, -16'sd3000, 16'd5000);
    send_sample(16'sd5000, -16'sd5000, 16'sd0, 16'd20000);
    send_sample(16'sd0, 16'sd32767, 16'sd0, 16'd30000);
    send_sample(16'sd32767, 16'sd32767, 16'sd32767, 16'd65535);
    send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 16'd65535);
    send_sample(16'sd32767, -16'sd32768, 16'sd0, 16'd65535);
    send_sample(16'sd0, 16'sd0, 16'sd0, 16'd0);
    repeat (NUM_RANDOM) send_random_sample();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
